// ===== hw/rtl/rths_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to hue/saturation package
// Shared types, constants and the restoring division step for the converter.
// ----------------------------------------------------------------------------
package rths_pkg;

  localparam int BITS_PER_STAGE = 2;
  localparam int DIV_STAGES     = 4;
  localparam int HUE_STAGES     = 3;
  localparam int PIPE_DEPTH     = DIV_STAGES + 2;

  localparam logic [7:0] SAT_SCALE        = 8'd254;
  localparam logic [5:0] HUE_SCALE        = 6'd43;
  localparam logic [7:0] HUE_OFFSET_RED   = 8'd0;
  localparam logic [7:0] HUE_OFFSET_GREEN = 8'd85;
  localparam logic [7:0] HUE_OFFSET_BLUE  = 8'd171;

  localparam logic [1:0] SECTOR_RED   = 2'd0;
  localparam logic [1:0] SECTOR_GREEN = 2'd1;
  localparam logic [1:0] SECTOR_BLUE  = 2'd2;

  typedef struct packed {
    logic [7:0] sat_rem;
    logic [7:0] sat_low;
    logic [7:0] sat_quo;
    logic [7:0] mx;
    logic [7:0] hue_rem;
    logic [5:0] hue_low;
    logic [5:0] hue_quo;
    logic [7:0] delta;
    logic       neg;
    logic [1:0] sector;
    logic       black;
    logic       grey;
  } work_t;

  // One restoring step: returns the quotient bit above the new remainder.
  function automatic logic [8:0] div_step(input logic [7:0] rem, input logic nbit,
                                          input logic [7:0] den);
    logic [8:0] trial;
    logic [8:0] diff;
    trial = {rem, nbit};
    diff  = trial - {1'b0, den};
    if (trial >= {1'b0, den}) begin
      return {1'b1, diff[7:0]};
    end else begin
      return {1'b0, trial[7:0]};
    end
  endfunction

endpackage

// ===== hw/rtl/rths_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to hue/saturation channels
// Valid/ready channels for the pixel requests and the result requests.
// ----------------------------------------------------------------------------
interface rths_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface rths_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] hue_out;
  logic [7:0] saturation_out;

  modport source (output valid, output hue_out, output saturation_out, input ready);
  modport sink (input valid, input hue_out, input saturation_out, output ready);
endinterface

// ===== hw/rtl/rgb_to_hue_saturation_8bit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to hue/saturation converter, 8-bit
// Converts one RGB pixel into a hue on a 0..255 circle and a saturation.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload                      Requests
//  pixel    in         red, green, blue             one per pixel
//  result   out        hue_out, saturation_out      one per pixel
//
// A pixel may be taken in every cycle while the pipeline is not stalled; each
// request is registered by the front stage, then passes through four divider
// stages and the output register before its result appears. Reset clears
// every valid bit and leaves the pipeline empty.
// A stalled result holds in the output register while earlier stages keep
// filling; each stage moves on only when the one after it has room.
module rgb_to_hue_saturation_8bit (
  input  logic                clk,
  input  logic                rst,
  rths_pixel_if.sink          pixel,
  rths_result_if.source       result
);

  logic            s0_valid;
  rths_pkg::work_t s0_work;
  rths_pkg::work_t s0_next;
  logic            div_in_ready;
  logic            div_out_valid;
  logic            div_out_ready;
  rths_pkg::work_t div_out;
  logic            s0_ready;

  logic [7:0]  mx;
  logic [7:0]  mn;
  logic [7:0]  delta;
  logic [7:0]  mag;
  logic [13:0] hue_num;
  logic [15:0] sat_num;

  logic [7:0] offset;
  logic [7:0] quo;
  logic [7:0] hue_next;
  logic [7:0] sat_next;

  assign s0_ready    = !s0_valid || div_in_ready;
  assign pixel.ready = s0_ready;

  always_comb begin
    mx = pixel.red;
    mn = pixel.red;
    if (pixel.green > mx) begin
      mx = pixel.green;
    end
    if (pixel.blue > mx) begin
      mx = pixel.blue;
    end
    if (pixel.green < mn) begin
      mn = pixel.green;
    end
    if (pixel.blue < mn) begin
      mn = pixel.blue;
    end
    delta = mx - mn;

    s0_next        = '0;
    s0_next.mx     = mx;
    s0_next.delta  = delta;
    s0_next.black  = (mx == 8'd0);
    s0_next.grey   = (delta == 8'd0);
    if (mx == pixel.red) begin
      s0_next.sector = rths_pkg::SECTOR_RED;
      s0_next.neg    = pixel.blue > pixel.green;
      mag = s0_next.neg ? pixel.blue - pixel.green : pixel.green - pixel.blue;
    end else if (mx == pixel.green) begin
      s0_next.sector = rths_pkg::SECTOR_GREEN;
      s0_next.neg    = pixel.red > pixel.blue;
      mag = s0_next.neg ? pixel.red - pixel.blue : pixel.blue - pixel.red;
    end else begin
      s0_next.sector = rths_pkg::SECTOR_BLUE;
      s0_next.neg    = pixel.green > pixel.red;
      mag = s0_next.neg ? pixel.green - pixel.red : pixel.red - pixel.green;
    end

    hue_num = 14'(mag) * 14'(rths_pkg::HUE_SCALE);
    sat_num = 16'(delta) * 16'(rths_pkg::SAT_SCALE);
    s0_next.sat_rem = sat_num[15:8];
    s0_next.sat_low = sat_num[7:0];
    s0_next.hue_rem = hue_num[13:6];
    s0_next.hue_low = hue_num[5:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (s0_ready) begin
      s0_valid <= pixel.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_ready && pixel.valid) begin
      s0_work <= s0_next;
    end
  end

  rths_divider u_divider (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s0_valid),
    .in_ready  (div_in_ready),
    .in_data   (s0_work),
    .out_valid (div_out_valid),
    .out_ready (div_out_ready),
    .out_data  (div_out)
  );

  always_comb begin
    case (div_out.sector)
      rths_pkg::SECTOR_GREEN: offset = rths_pkg::HUE_OFFSET_GREEN;
      rths_pkg::SECTOR_BLUE:  offset = rths_pkg::HUE_OFFSET_BLUE;
      default:                offset = rths_pkg::HUE_OFFSET_RED;
    endcase
    quo = {2'b00, div_out.hue_quo};
    if (div_out.black || div_out.grey) begin
      hue_next = 8'd0;
    end else if (div_out.neg) begin
      hue_next = offset - quo;
    end else begin
      hue_next = offset + quo;
    end
    sat_next = div_out.black ? 8'd0 : div_out.sat_quo;
  end

  assign div_out_ready = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (div_out_ready) begin
      result.valid <= div_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (div_out_ready && div_out_valid) begin
      result.hue_out        <= hue_next;
      result.saturation_out <= sat_next;
    end
  end

endmodule

// ===== hw/rtl/rths_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to hue/saturation divider pipeline
// Restoring division for saturation and hue, two quotient bits per stage; hue bits only in the first HUE_STAGES stages.
// ----------------------------------------------------------------------------
module rths_divider (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  rths_pkg::work_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output rths_pkg::work_t out_data
);

  logic            valid [rths_pkg::DIV_STAGES];
  logic            ready [rths_pkg::DIV_STAGES + 1];
  rths_pkg::work_t work  [rths_pkg::DIV_STAGES];
  rths_pkg::work_t src   [rths_pkg::DIV_STAGES];
  rths_pkg::work_t work_next [rths_pkg::DIV_STAGES];
  logic            src_valid [rths_pkg::DIV_STAGES];

  assign in_ready = ready[0];
  assign ready[rths_pkg::DIV_STAGES] = out_ready;
  assign out_valid = valid[rths_pkg::DIV_STAGES - 1];
  assign out_data  = work[rths_pkg::DIV_STAGES - 1];

  for (genvar j = 0; j < rths_pkg::DIV_STAGES; j++) begin : g_stage
    if (j == 0) begin : g_first
      assign src[j]       = in_data;
      assign src_valid[j] = in_valid;
    end else begin : g_rest
      assign src[j]       = work[j - 1];
      assign src_valid[j] = valid[j - 1];
    end

    assign ready[j] = !valid[j] || ready[j + 1];

    always_comb begin
      logic [8:0] res;
      work_next[j] = src[j];
      for (int b = 0; b < rths_pkg::BITS_PER_STAGE; b++) begin
        res = rths_pkg::div_step(work_next[j].sat_rem, work_next[j].sat_low[7],
                                 work_next[j].mx);
        work_next[j].sat_rem = res[7:0];
        work_next[j].sat_quo = {work_next[j].sat_quo[6:0], res[8]};
        work_next[j].sat_low = {work_next[j].sat_low[6:0], 1'b0};
        if (j < rths_pkg::HUE_STAGES) begin
          res = rths_pkg::div_step(work_next[j].hue_rem, work_next[j].hue_low[5],
                                   work_next[j].delta);
          work_next[j].hue_rem = res[7:0];
          work_next[j].hue_quo = {work_next[j].hue_quo[4:0], res[8]};
          work_next[j].hue_low = {work_next[j].hue_low[4:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[j] <= 1'b0;
      end else if (ready[j]) begin
        valid[j] <= src_valid[j];
      end
    end

    always_ff @(posedge clk) begin
      if (ready[j] && src_valid[j]) begin
        work[j] <= work_next[j];
      end
    end
  end

endmodule

// ===== hw/rtl/rths_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to hue/saturation port checker
// Watches the converter's ports for invented, malformed or changed stalled results.
// ----------------------------------------------------------------------------
module rths_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] hue_out,
  input logic [7:0] saturation_out
);

  logic [3:0] inflight;
  logic       in_take;
  logic       out_take;

  assign in_take  = in_valid && in_ready;
  assign out_take = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= 4'd0;
    end else if (in_take && !out_take) begin
      inflight <= inflight + 4'd1;
    end else if (out_take && !in_take) begin
      inflight <= inflight - 4'd1;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hue_out) && $stable(saturation_out))
    else $error("stalled result changed");

  a_sat_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> saturation_out <= 8'd254)
    else $error("saturation above range");

  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> inflight != 4'd0)
    else $error("result without a request");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    inflight <= 4'(rths_pkg::PIPE_DEPTH))
    else $error("more requests in flight than pipeline stages");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

endmodule

bind rgb_to_hue_saturation_8bit rths_checker u_rths_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (pixel.valid),
  .in_ready       (pixel.ready),
  .out_valid      (result.valid),
  .out_ready      (result.ready),
  .hue_out        (result.hue_out),
  .saturation_out (result.saturation_out)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to hue/saturation converter testbench
// Sends pixel requests, first chosen corner cases and then random pixels,
// while both channels idle and stall at random in several phases. An
// in-bench model works out the hue and saturation of every accepted pixel,
// and each result request is checked against the oldest value waiting.
// ----------------------------------------------------------------------------
module tb;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] sat;
  } hue_sat_t;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = rths_pkg::PIPE_DEPTH + 8;

  logic clk = 1'b0;
  logic rst;

  rths_pixel_if  pixel_ch ();
  rths_result_if result_ch ();

  hue_sat_t hue_sat_q[$];
  int       err_count      = 0;
  int       send_idle_pct  = 0;
  int       recv_stall_pct = 0;
  int       quiet_cycles   = 0;

  rgb_to_hue_saturation_8bit u_dut (
    .clk    (clk),
    .rst    (rst),
    .pixel  (pixel_ch),
    .result (result_ch)
  );

  always #5 clk = ~clk;

  function automatic hue_sat_t predict_hue_sat(input logic [7:0] r, input logic [7:0] g,
                                               input logic [7:0] b);
    int       mx;
    int       mn;
    int       delta;
    int       h;
    hue_sat_t res;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    delta = mx - mn;
    if (mx == 0) begin
      return '0;
    end
    res.sat = 8'((delta * 254) / mx);
    if (delta == 0) begin
      h = 0;
    end else if (mx == int'(r)) begin
      h = (43 * (int'(g) - int'(b))) / delta;
    end else if (mx == int'(g)) begin
      h = 85 + (43 * (int'(b) - int'(r))) / delta;
    end else begin
      h = 171 + (43 * (int'(r) - int'(g))) / delta;
    end
    if (h < 0) h += 256;
    if (h > 255) h -= 256;
    res.hue = 8'(h);
    return res;
  endfunction

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      pixel_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pixel_ch.valid <= 1'b1;
    pixel_ch.red   <= r;
    pixel_ch.green <= g;
    pixel_ch.blue  <= b;
    @(posedge clk);
    while (!pixel_ch.ready) @(posedge clk);
    hue_sat_q.push_back(predict_hue_sat(r, g, b));
  endtask

  task automatic drain_results();
    pixel_ch.valid <= 1'b0;
    @(posedge clk);
    while (hue_sat_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    hue_sat_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (hue_sat_q.size() == 0) begin
        $error("unexpected result request: hue_out %0d, saturation_out %0d",
               result_ch.hue_out, result_ch.saturation_out);
        err_count++;
      end else begin
        want = hue_sat_q.pop_front();
        if (result_ch.hue_out !== want.hue) begin
          $error("hue_out mismatch: expected %0d, actual %0d", want.hue, result_ch.hue_out);
          err_count++;
        end
        if (result_ch.saturation_out !== want.sat) begin
          $error("saturation_out mismatch: expected %0d, actual %0d",
                 want.sat, result_ch.saturation_out);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (pixel_ch.valid && pixel_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic test_black_and_grey();
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd1, 8'd1, 8'd1);
    send_pixel(8'd128, 8'd128, 8'd128);
  endtask

  task automatic test_primaries_and_ties();
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd170, 8'd170, 8'd85);
  endtask

  task automatic test_hue_wrap_and_rounding();
    send_pixel(8'd255, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd1, 8'd0);
    send_pixel(8'd128, 8'd127, 8'd127);
    send_pixel(8'd10, 8'd255, 8'd250);
    send_pixel(8'd0, 8'd1, 8'd2);
    send_pixel(8'd200, 8'd100, 8'd250);
    send_pixel(8'd254, 8'd1, 8'd255);
    send_pixel(8'd85, 8'd170, 8'd42);
  endtask

  task automatic test_random_pixels(input int count, input int idle_pct, input int stall_pct);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    int         kind;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      r    = 8'($urandom);
      g    = 8'($urandom);
      b    = 8'($urandom);
      kind = $urandom_range(9);
      case (kind)
        0: begin
          g = r;
          b = r;
        end
        1: begin
          if ($urandom_range(1)) g = r;
          else b = r;
          if (b == r && g > r) b = g;
        end
        2: begin
          r = 8'($urandom_range(3));
          g = 8'($urandom_range(3));
          b = 8'($urandom_range(3));
        end
        3: begin
          b = g;
        end
        default: begin
        end
      endcase
      send_pixel(r, g, b);
    end
    drain_results();
  endtask

  initial begin
    rst              <= 1'b1;
    pixel_ch.valid   <= 1'b0;
    pixel_ch.red     <= 8'd0;
    pixel_ch.green   <= 8'd0;
    pixel_ch.blue    <= 8'd0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_black_and_grey();
    test_primaries_and_ties();
    test_hue_wrap_and_rounding();
    drain_results();

    test_random_pixels(400, 0, 0);
    test_random_pixels(400, 55, 0);
    test_random_pixels(400, 0, 55);
    test_random_pixels(400, 25, 25);

    if (err_count == 0 && hue_sat_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      if (hue_sat_q.size() != 0) begin
        $error("%0d expected results never arrived", hue_sat_q.size());
      end
      $display("simulation failed");
    end
    $finish;
  end

endmodule
